/* rtl/btdh_pkg.sv */
// ----------------------------------------------------------------------------
// btdh_pkg
// Shared types and constants for the button tap / double tap / hold classifier.
// ----------------------------------------------------------------------------
package btdh_pkg;

  // timestamp and register widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [CFG_W-1:0] TAP_RST      = 16'd300;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd400;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd2000;

  // register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TAP      = 2'd1,
    REG_WINDOW   = 2'd2,
    REG_HOLD     = 2'd3
  } reg_idx_t;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_TAP    = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_HOLD   = 2'd3
  } event_t;

  // press classifier phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSING = 2'd1,
    PH_AFTER    = 2'd2,
    PH_HELD     = 2'd3
  } phase_t;

  // configuration seen by the classifier
  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] tap_limit;
    logic [CFG_W-1:0] double_tap_window;
    logic [CFG_W-1:0] hold_limit;
  } cfg_t;

endpackage

/* rtl/button_tap_double_hold_classifier_unit.sv */
// ----------------------------------------------------------------------------
// button_tap_double_hold_classifier_unit
// Debounced button classifier with a stream input, a stream output and a
// register port.
// ----------------------------------------------------------------------------
// One poll item enters per clock and its result item is written to a two-deep
// output queue in the same cycle, so a steady stream runs at one item per
// cycle; the only limit is the output queue, which holds input off when two
// results are waiting. Each input item gives exactly one result item: the
// event code and the timestamp of the most recent event. Registers at byte
// addresses 0, 4, 8 and 12 hold debounce time, tap limit, double tap window
// and hold limit (16 bits each, in milliseconds); write them only while idle.
module button_tap_double_hold_classifier_unit import btdh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] event_code, [33:2] last_event_time, rest zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RES_W = 2 + TIME_W;

  cfg_t              cfg;
  reg_idx_t          wr_idx;
  logic              cfg_wr;
  logic              s_accept;
  logic              m_accept;
  event_t            event_code;
  logic [TIME_W-1:0] last_event_time;

  logic [RES_W-1:0]  queue [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time     <= DEBOUNCE_RST;
      cfg.tap_limit         <= TAP_RST;
      cfg.double_tap_window <= WINDOW_RST;
      cfg.hold_limit        <= HOLD_RST;
    end else if (cfg_wr) begin
      unique case (wr_idx)
        REG_DEBOUNCE: cfg.debounce_time     <= pwdata[CFG_W-1:0];
        REG_TAP:      cfg.tap_limit         <= pwdata[CFG_W-1:0];
        REG_WINDOW:   cfg.double_tap_window <= pwdata[CFG_W-1:0];
        REG_HOLD:     cfg.hold_limit        <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (wr_idx)
      REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_time};
      REG_TAP:      prdata = {16'd0, cfg.tap_limit};
      REG_WINDOW:   prdata = {16'd0, cfg.double_tap_window};
      REG_HOLD:     prdata = {16'd0, cfg.hold_limit};
      default:      prdata = '0;
    endcase
  end

  // handshakes, input held off while in reset
  assign s_tready = !rst && (count != 2'd2);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_accept = m_tvalid && m_tready;

  btdh_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .step_en         (s_accept),
    .pin_level       (s_tdata[0]),
    .now_ms          (s_tdata[32:1]),
    .event_code      (event_code),
    .last_event_time (last_event_time)
  );

  // output queue, two items deep
  always_ff @(posedge clk) begin
    if (s_accept) queue[wr_ptr] <= {last_event_time, event_code};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s_accept) wr_ptr <= ~wr_ptr;
      if (m_accept) rd_ptr <= ~rd_ptr;
      unique case ({s_accept, m_accept})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign m_tdata = {6'd0, queue[rd_ptr]};

endmodule

/* rtl/btdh_core.sv */
// ----------------------------------------------------------------------------
// btdh_core
// Debouncer and press classifier state; advances by one poll per enabled cycle.
// ----------------------------------------------------------------------------
module btdh_core import btdh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              step_en,
  input  logic              pin_level,
  input  logic [TIME_W-1:0] now_ms,
  output event_t            event_code,
  output logic [TIME_W-1:0] last_event_time
);

  phase_t            phase, phase_next;
  logic [TIME_W-1:0] press_start, press_start_next;
  logic [TIME_W-1:0] tap_release, tap_release_next;
  logic              second_press, second_press_next;
  logic              raw_pressed_last;
  logic [TIME_W-1:0] stable_since, stable_since_next;
  logic              debounced_pressed, debounced_pressed_next;
  logic [TIME_W-1:0] last_event_stamp, last_event_stamp_next;

  logic              raw;
  logic [TIME_W-1:0] stable_age;
  logic [TIME_W-1:0] dur;
  logic [TIME_W-1:0] since_tap;
  logic              pressed;
  logic              is_tap;
  logic              is_hold;
  logic              window_over;
  event_t            ev;

  // debounce: restart the stable timer on any raw change
  assign raw               = ~pin_level;
  assign stable_since_next = (raw != raw_pressed_last) ? now_ms : stable_since;
  assign stable_age        = now_ms - stable_since_next;
  assign debounced_pressed_next =
    (stable_age >= TIME_W'(cfg.debounce_time)) ? raw : debounced_pressed;
  assign pressed = debounced_pressed_next;

  // elapsed times, wrapping
  assign dur         = now_ms - press_start;
  assign since_tap   = now_ms - tap_release;
  assign is_tap      = dur < TIME_W'(cfg.tap_limit);
  assign is_hold     = dur >= TIME_W'(cfg.hold_limit);
  assign window_over = since_tap >= TIME_W'(cfg.double_tap_window);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) phase_next = PH_PRESSING;
      end
      PH_PRESSING: begin
        if (!pressed) begin
          if (is_tap && !second_press) phase_next = PH_AFTER;
          else                         phase_next = PH_IDLE;
        end else if (is_hold) begin
          phase_next = PH_HELD;
        end
      end
      PH_AFTER: begin
        if (pressed)          phase_next = PH_PRESSING;
        else if (window_over) phase_next = PH_IDLE;
      end
      PH_HELD: begin
        if (!pressed) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // event and press bookkeeping
  always_comb begin
    ev                = EV_NONE;
    press_start_next  = press_start;
    tap_release_next  = tap_release;
    second_press_next = second_press;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          press_start_next  = now_ms;
          second_press_next = 1'b0;
        end
      end
      PH_PRESSING: begin
        if (!pressed) begin
          priority if (is_tap) begin
            if (second_press) begin
              ev                = EV_DOUBLE;
              second_press_next = 1'b0;
            end else begin
              ev               = EV_TAP;
              tap_release_next = now_ms;
            end
          end else if (is_hold) begin
            ev                = EV_HOLD;
            second_press_next = 1'b0;
          end else begin
            second_press_next = 1'b0;
          end
        end else if (is_hold) begin
          ev                = EV_HOLD;
          second_press_next = 1'b0;
        end
      end
      PH_AFTER: begin
        if (pressed) begin
          press_start_next  = now_ms;
          second_press_next = 1'b1;
        end
      end
      PH_HELD: begin
      end
      default: begin
      end
    endcase
  end

  assign last_event_stamp_next = (ev != EV_NONE) ? now_ms : last_event_stamp;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      press_start       <= '0;
      tap_release       <= '0;
      second_press      <= 1'b0;
      raw_pressed_last  <= 1'b1;
      stable_since      <= '0;
      debounced_pressed <= 1'b0;
      last_event_stamp  <= '0;
    end else if (step_en) begin
      phase             <= phase_next;
      press_start       <= press_start_next;
      tap_release       <= tap_release_next;
      second_press      <= second_press_next;
      raw_pressed_last  <= raw;
      stable_since      <= stable_since_next;
      debounced_pressed <= debounced_pressed_next;
      last_event_stamp  <= last_event_stamp_next;
    end
  end

  assign event_code      = ev;
  assign last_event_time = last_event_stamp_next;

endmodule

/* rtl/btdh_checker.sv */
// ----------------------------------------------------------------------------
// btdh_checker
// Port-level checks for the button classifier, bound to the top level.
// ----------------------------------------------------------------------------
module btdh_checker import btdh_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // no result item right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item shown right after reset");

  // input held off only while results are queued
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result item waiting");

  // an input item always leaves a result item to take
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted item gave no result item");

  // stalled result stays put
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result item changed");

  // a register write reads back
  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |=>
      ($past(rst) || paddr[3:2] != $past(paddr[3:2]) ||
       prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("register did not read back the written value");

endmodule

bind button_tap_double_hold_classifier_unit btdh_checker u_btdh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);
